// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/stt_pkg.sv -----
package stt_pkg;

    // Token kinds.
    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_ERROR  = 6'd1;
    localparam logic [5:0] K_NUMBER = 6'd2;
    localparam logic [5:0] K_STRING = 6'd3;
    localparam logic [5:0] K_COLOUR = 6'd4;
    localparam logic [5:0] K_LBRACE = 6'd5;
    localparam logic [5:0] K_RBRACE = 6'd6;
    localparam logic [5:0] K_IDENT  = 6'd7;
    localparam logic [5:0] K_KEY0   = 6'd8;

    // Error codes.
    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_COLOUR = 2'd1;
    localparam logic [1:0] E_STRING = 2'd2;
    localparam logic [1:0] E_CHAR   = 2'd3;

    // Most tokens one source byte can complete.
    localparam int MAX_TOK = 3;

    // Keyword table, each entry right-justified, first character highest.
    localparam int NUM_KW = 39;
    localparam int KW_CHARS = 11;
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [NUM_KW] = '{
        "canvas", "background", "camera", "light", "group",
        "circle", "rect", "line", "triangle", "text",
        "cube", "sphere", "pyramid", "plane", "cylinder",
        "pos", "radius", "size", "color", "rotate", "scale", "opacity", "fill",
        "from", "to", "width", "height", "base", "content", "type", "intensity",
        "p1", "p2", "p3",
        "solid", "wireframe",
        "point", "directional", "ambient"
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd6, 4'd10, 4'd6, 4'd5, 4'd5,
        4'd6, 4'd4, 4'd4, 4'd8, 4'd4,
        4'd4, 4'd6, 4'd7, 4'd5, 4'd8,
        4'd3, 4'd6, 4'd4, 4'd5, 4'd6, 4'd5, 4'd7, 4'd4,
        4'd4, 4'd2, 4'd5, 4'd6, 4'd4, 4'd7, 4'd4, 4'd9,
        4'd2, 4'd2, 4'd2,
        4'd5, 4'd9,
        4'd5, 4'd11, 4'd7
    };

    // One result token.
    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [31:0] start;
        logic [31:0] len;
        logic [15:0] line;
        logic [31:0] mant;
        logic [4:0]  frac;
        logic [23:0] rgb;
        logic        last;
    } t_tok;

    // Tokens produced by one accepted byte.
    typedef struct packed {
        logic [1:0]           num;
        t_tok [MAX_TOK-1:0]   tok;
    } t_burst;

endpackage

// ----- src/stt_scan.sv -----
module stt_scan #(
    parameter int MAX_KEYWORD_LENGTH = 11,
    parameter int POSITION_BITS = 32,
    parameter int LINE_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_byte,
    input  logic           i_end,
    output stt_pkg::t_burst o_burst
);
    import stt_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int LB = LINE_BITS;
    localparam int MKL = MAX_KEYWORD_LENGTH;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_HASH    = 12'b000000000010,
        S_SLASH   = 12'b000000000100,
        S_MINUS   = 12'b000000001000,
        S_COMMENT = 12'b000000010000,
        S_COLOUR  = 12'b000000100000,
        S_INT     = 12'b000001000000,
        S_DOT     = 12'b000010000000,
        S_FRAC    = 12'b000100000000,
        S_STRING  = 12'b001000000000,
        S_WORD    = 12'b010000000000,
        S_ERROR   = 12'b100000000000
    } t_mode;

    t_mode          r_mode, m;
    logic [PB-1:0]  r_pos, p, r_tb, tb, idx;
    logic [LB-1:0]  r_line, ln;
    logic [2:0]     r_hc, hc;
    logic [23:0]    r_cv, cv;
    logic [31:0]    r_dv, dv;
    logic [4:0]     r_fc, fc;
    logic           r_ng, ng;
    logic [7:0]     r_wb [MKL];
    logic [7:0]     wb [MKL];
    t_burst         burst;
    logic [1:0]     nres;
    logic           absorbed;
    logic [4:0]     hx;
    logic [7:0]     c;

    function automatic t_tok mk(input logic [5:0] kind, input logic [1:0] err,
                                input logic [31:0] start, input logic [31:0] len,
                                input logic [31:0] mant, input logic [4:0] frac,
                                input logic [23:0] rgb, input logic [15:0] line);
        t_tok t;
        t.kind = kind; t.err = err; t.start = start; t.len = len; t.line = line;
        t.mant = mant; t.frac = frac; t.rgb = rgb; t.last = 1'b0;
        return t;
    endfunction

    function automatic logic is_dig(input logic [7:0] ch);
        return (ch >= "0") && (ch <= "9");
    endfunction

    function automatic logic is_alp(input logic [7:0] ch);
        return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_of(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        if (is_dig(ch)) begin
            d = ch - "0";
            return {1'b1, d[3:0]};
        end
        if ((ch >= "a") && (ch <= "f")) begin
            d = ch - "a" + 8'd10;
            return {1'b1, d[3:0]};
        end
        if ((ch >= "A") && (ch <= "F")) begin
            d = ch - "A" + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // Keyword lookup over the first bytes of the word.
    function automatic logic [5:0] word_kind(input logic [7:0] w [MKL],
                                             input logic [PB-1:0] len);
        logic [8*KW_CHARS-1:0] pk [KW_CHARS+1];
        logic [5:0] kind;
        kind = K_IDENT;
        for (int n = 0; n <= KW_CHARS; n++) begin
            pk[n] = '0;
            for (int j = 0; j < KW_CHARS; j++) begin
                if (j < n) pk[n] = {pk[n][8*KW_CHARS-9:0], w[j]};
            end
        end
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if ((len == PB'(KW_LEN[k])) && (pk[KW_LEN[k]] == KW_TEXT[k])) begin
                kind = K_KEY0 + 6'(k);
            end
        end
        return kind;
    endfunction

    // Saturating decimal step; bit 32 flags that the limit was exceeded.
    function automatic logic [32:0] dec_step(input logic [31:0] v, input logic [7:0] ch,
                                             input logic neg);
        logic [35:0] s;
        logic [35:0] lim;
        logic [7:0] d;
        d = ch - "0";
        lim = neg ? 36'h080000000 : 36'h07FFFFFFF;
        s = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {32'd0, d[3:0]};
        if (s > lim) return {1'b1, lim[31:0]};
        return {1'b0, s[31:0]};
    endfunction

    function automatic logic [31:0] num_mant(input logic [31:0] v, input logic neg);
        return neg ? (32'd0 - v) : v;
    endfunction

    // Per-byte scan, following the order of the source grammar.
    always_comb begin
        logic [32:0] st;
        m = r_mode; p = r_pos; ln = r_line; tb = r_tb; hc = r_hc; cv = r_cv;
        dv = r_dv; fc = r_fc; ng = r_ng; wb = r_wb;
        burst = '0;
        nres = 2'd0;
        absorbed = 1'b0;
        c = i_byte;
        hx = hex_of(c);
        idx = p - tb;
        st = '0;
        if (i_take && (c != 8'd0)) begin
            // Byte inside the current token.
            case (m)
                S_HASH: begin
                    absorbed = 1'b1;
                    if (hx[4]) begin
                        m = S_COLOUR; hc = 3'd1; cv = {20'd0, hx[3:0]};
                    end else if (c == 8'h0A) begin
                        m = S_IDLE; absorbed = 1'b0;
                    end else begin
                        m = S_COMMENT;
                    end
                end
                S_COMMENT: begin
                    absorbed = 1'b1;
                    if (c == 8'h0A) begin
                        m = S_IDLE; absorbed = 1'b0;
                    end
                end
                S_SLASH: begin
                    absorbed = 1'b1;
                    if (c == "/") begin
                        m = S_COMMENT;
                    end else begin
                        burst.tok[nres] = mk(K_ERROR, E_CHAR, 32'(tb), '0, '0, '0, '0,
                                             16'(ln));
                        nres = nres + 2'd1; m = S_ERROR;
                    end
                end
                S_MINUS: begin
                    absorbed = 1'b1;
                    if (is_dig(c)) begin
                        m = S_INT; st = dec_step(dv, c, ng); dv = st[31:0];
                    end else begin
                        burst.tok[nres] = mk(K_ERROR, E_CHAR, 32'(tb), '0, '0, '0, '0,
                                             16'(ln));
                        nres = nres + 2'd1; m = S_ERROR;
                    end
                end
                S_COLOUR: begin
                    if (hx[4]) begin
                        absorbed = 1'b1;
                        if (hc < 3'd7) hc = hc + 3'd1;
                        cv = {cv[19:0], hx[3:0]};
                    end else if (hc == 3'd6) begin
                        burst.tok[nres] = mk(K_COLOUR, E_NONE, 32'(tb), 32'(p - tb), '0,
                                             '0, cv, 16'(ln));
                        nres = nres + 2'd1; m = S_IDLE;
                    end else begin
                        absorbed = 1'b1;
                        burst.tok[nres] = mk(K_ERROR, E_COLOUR, 32'(tb), '0, '0, '0, '0,
                                             16'(ln));
                        nres = nres + 2'd1; m = S_ERROR;
                    end
                end
                S_INT: begin
                    if (is_dig(c)) begin
                        absorbed = 1'b1; st = dec_step(dv, c, ng); dv = st[31:0];
                    end else if (c == ".") begin
                        absorbed = 1'b1; m = S_DOT;
                    end else begin
                        burst.tok[nres] = mk(K_NUMBER, E_NONE, 32'(tb), 32'(p - tb),
                                             num_mant(dv, ng), fc, '0, 16'(ln));
                        nres = nres + 2'd1; m = S_IDLE;
                    end
                end
                S_DOT: begin
                    absorbed = 1'b1;
                    if (is_dig(c)) begin
                        m = S_FRAC;
                        st = dec_step(dv, c, ng);
                        if ((fc < 5'd31) && !st[32]) begin
                            dv = st[31:0]; fc = fc + 5'd1;
                        end
                    end else begin
                        burst.tok[nres] = mk(K_NUMBER, E_NONE, 32'(tb),
                                             32'(p - PB'(1) - tb), num_mant(dv, ng), fc,
                                             '0, 16'(ln));
                        nres = nres + 2'd1;
                        burst.tok[nres] = mk(K_ERROR, E_CHAR, 32'(p - PB'(1)), '0, '0, '0,
                                             '0, 16'(ln));
                        nres = nres + 2'd1; m = S_ERROR;
                    end
                end
                S_FRAC: begin
                    if (is_dig(c)) begin
                        absorbed = 1'b1;
                        st = dec_step(dv, c, ng);
                        if ((fc < 5'd31) && !st[32]) begin
                            dv = st[31:0]; fc = fc + 5'd1;
                        end
                    end else begin
                        burst.tok[nres] = mk(K_NUMBER, E_NONE, 32'(tb), 32'(p - tb),
                                             num_mant(dv, ng), fc, '0, 16'(ln));
                        nres = nres + 2'd1; m = S_IDLE;
                    end
                end
                S_STRING: begin
                    absorbed = 1'b1;
                    if (c == 8'h22) begin
                        burst.tok[nres] = mk(K_STRING, E_NONE, 32'(tb), 32'(p - tb), '0,
                                             '0, '0, 16'(ln));
                        nres = nres + 2'd1; m = S_IDLE;
                    end else if (c == 8'h0A) begin
                        if (ln != '1) ln = ln + LB'(1);
                    end
                end
                S_WORD: begin
                    if (is_alp(c) || is_dig(c) || (c == "_")) begin
                        absorbed = 1'b1;
                        for (int i = 0; i < MKL; i++) begin
                            if (idx == PB'(i)) wb[i] = c;
                        end
                    end else begin
                        burst.tok[nres] = mk(word_kind(wb, p - tb), E_NONE, 32'(tb),
                                             32'(p - tb), '0, '0, '0, 16'(ln));
                        nres = nres + 2'd1; m = S_IDLE;
                    end
                end
                S_ERROR: absorbed = 1'b1;
                default: absorbed = 1'b0;
            endcase

            // Byte between tokens.
            if (!absorbed) begin
                if ((c == " ") || (c == 8'h09) || (c == 8'h0D)) begin
                    m = S_IDLE;
                end else if (c == 8'h0A) begin
                    if (ln != '1) ln = ln + LB'(1);
                end else if (c == "#") begin
                    m = S_HASH; tb = p;
                end else if (c == "/") begin
                    m = S_SLASH; tb = p;
                end else if (c == "-") begin
                    m = S_MINUS; tb = p; ng = 1'b1; dv = '0; fc = '0;
                end else if (is_dig(c)) begin
                    m = S_INT; tb = p; ng = 1'b0; fc = '0;
                    st = dec_step(32'd0, c, 1'b0); dv = st[31:0];
                end else if (c == 8'h22) begin
                    m = S_STRING; tb = p + PB'(1);
                end else if (is_alp(c) || (c == "_")) begin
                    m = S_WORD; tb = p; wb[0] = c;
                end else if (c == "{") begin
                    burst.tok[nres] = mk(K_LBRACE, E_NONE, 32'(p), 32'd1, '0, '0, '0,
                                         16'(ln));
                    nres = nres + 2'd1;
                end else if (c == "}") begin
                    burst.tok[nres] = mk(K_RBRACE, E_NONE, 32'(p), 32'd1, '0, '0, '0,
                                         16'(ln));
                    nres = nres + 2'd1;
                end else begin
                    burst.tok[nres] = mk(K_ERROR, E_CHAR, 32'(p), '0, '0, '0, '0, 16'(ln));
                    nres = nres + 2'd1; m = S_ERROR;
                end
            end
            p = p + PB'(1);
        end

        // End of text: close the pending token, then eof and a fresh start.
        if (i_take && ((c == 8'd0) || i_end)) begin
            case (m)
                S_SLASH, S_MINUS: begin
                    burst.tok[nres] = mk(K_ERROR, E_CHAR, 32'(tb), '0, '0, '0, '0, 16'(ln));
                    nres = nres + 2'd1;
                end
                S_COLOUR: begin
                    if (hc == 3'd6) begin
                        burst.tok[nres] = mk(K_COLOUR, E_NONE, 32'(tb), 32'(p - tb), '0,
                                             '0, cv, 16'(ln));
                    end else begin
                        burst.tok[nres] = mk(K_ERROR, E_COLOUR, 32'(tb), '0, '0, '0, '0,
                                             16'(ln));
                    end
                    nres = nres + 2'd1;
                end
                S_INT, S_FRAC: begin
                    burst.tok[nres] = mk(K_NUMBER, E_NONE, 32'(tb), 32'(p - tb),
                                         num_mant(dv, ng), fc, '0, 16'(ln));
                    nres = nres + 2'd1;
                end
                S_DOT: begin
                    burst.tok[nres] = mk(K_NUMBER, E_NONE, 32'(tb), 32'(p - PB'(1) - tb),
                                         num_mant(dv, ng), fc, '0, 16'(ln));
                    nres = nres + 2'd1;
                    burst.tok[nres] = mk(K_ERROR, E_CHAR, 32'(p - PB'(1)), '0, '0, '0, '0,
                                         16'(ln));
                    nres = nres + 2'd1;
                end
                S_STRING: begin
                    burst.tok[nres] = mk(K_ERROR, E_STRING, 32'(tb), '0, '0, '0, '0,
                                         16'(ln));
                    nres = nres + 2'd1;
                end
                S_WORD: begin
                    burst.tok[nres] = mk(word_kind(wb, p - tb), E_NONE, 32'(tb),
                                         32'(p - tb), '0, '0, '0, 16'(ln));
                    nres = nres + 2'd1;
                end
                default: nres = nres;
            endcase
            burst.tok[nres] = mk(K_EOF, E_NONE, 32'(p), '0, '0, '0, '0, 16'(ln));
            nres = nres + 2'd1;
            m = S_IDLE; p = '0; ln = LB'(1); tb = '0;
        end

        // Mark the final token of this byte.
        if (nres != 2'd0) burst.tok[nres - 2'd1].last = 1'b1;
        burst.num = nres;
    end

    assign o_burst = burst;

    // Scanner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE;
            r_pos  <= '0;
            r_line <= LB'(1);
            r_tb   <= '0;
            r_hc   <= '0;
            r_cv   <= '0;
            r_dv   <= '0;
            r_fc   <= '0;
            r_ng   <= 1'b0;
        end else if (i_take) begin
            r_mode <= m;
            r_pos  <= p;
            r_line <= ln;
            r_tb   <= tb;
            r_hc   <= hc;
            r_cv   <= cv;
            r_dv   <= dv;
            r_fc   <= fc;
            r_ng   <= ng;
        end
    end

    // Word bytes carry no reset; only written entries are ever compared.
    always_ff @(posedge i_clk) begin
        if (i_take) r_wb <= wb;
    end

endmodule

// ----- src/scene_text_tokenizer.sv -----
// Each accepted byte is scanned in the cycle of its transfer; its tokens are registered
// into a four-entry result queue that sends one token per cycle while m_axis_tready is
// high. Throughput is one byte per cycle while each byte yields at most one token and
// the output is not stalled; a byte is taken whenever the queue holds at most one token.
// Synchronous active-low reset clears the scanner to idle, position 0, line 1, and
// empties the result queue.
module scene_text_tokenizer #(
    parameter int MAX_KEYWORD_LENGTH = 11,
    parameter int POSITION_BITS = 32,
    parameter int LINE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // text_byte
    input  logic         s_axis_tlast,   // end_of_text
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // error_code[1:0], start_offset[33:2], token_length[65:34], line_number[81:66],
    // mantissa[113:82], fraction_digits[118:114], red[126:119], green[134:127],
    // blue[142:135], zero pad[143]
    output logic [143:0] m_axis_tdata,
    output logic [5:0]   m_axis_tuser,   // token_kind
    output logic         m_axis_tlast    // last_of_run
);
    import stt_pkg::*;

    `include "assert_macros.svh"

    localparam int QD = 4;

    t_burst      burst;
    logic        take;
    logic        pop;
    t_tok        r_q [QD];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;
    t_tok        head;

    assign s_axis_tready = (r_cnt <= 3'd1);
    assign take = s_axis_tvalid && s_axis_tready;
    assign pop  = m_axis_tvalid && m_axis_tready;

    stt_scan #(
        .MAX_KEYWORD_LENGTH(MAX_KEYWORD_LENGTH),
        .POSITION_BITS(POSITION_BITS),
        .LINE_BITS(LINE_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .o_burst (burst)
    );

    // Queue fill level.
    assign n_cnt = r_cnt + {1'b0, burst.num} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + burst.num;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

    // Queue storage, written in order of the tokens of one byte.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_TOK; i++) begin
            if (2'(i) < burst.num) r_q[r_wp + 2'(i)] <= burst.tok[i];
        end
    end

    // Head of the queue drives the output transfer.
    assign head = r_q[r_rp];
    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {1'b0, head.rgb[7:0], head.rgb[15:8], head.rgb[23:16],
                            head.frac, head.mant, head.line, head.len, head.start,
                            head.err};

    `ASSERT_CLK(a_q_bound, i_clk, i_rst_n, r_cnt <= 3'(QD), "result queue overflow")
    `ASSERT_CLK(a_eot_emits, i_clk, i_rst_n, (take && s_axis_tlast) |-> (burst.num != 2'd0),
                "end of text produced no token")
    `ASSERT_CLK(a_pop_only, i_clk, i_rst_n,
                (!take && pop) |=> (r_cnt == $past(r_cnt) - 3'd1),
                "queue level changed without a transfer")
    `ASSERT_CLK(a_idle_hold, i_clk, i_rst_n, (!take && !pop) |=> $stable(r_cnt),
                "queue level drifted while idle")
endmodule
